[src/phash_pkg.sv]
// package for the polyval hash accumulator: field widths, register indexes,
// carry-less multiply and reduction fold helpers
// no dependencies
`timescale 1ns / 1ps

package phash_pkg;

   localparam int HalfWidth  = 64;
   localparam int BlockWidth = 2 * HalfWidth;
   localparam int CsrIdxWidth = 8;

   typedef logic [HalfWidth-1:0]  half_type;
   typedef logic [BlockWidth-1:0] block_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;

   // register indexes on the csr port
   localparam csr_idx_type CsrHashKeyLo = 8'd0;
   localparam csr_idx_type CsrHashKeyHi = 8'd1;

   // reduction polynomial tail x^57 + x^62 + x^63 as shift amounts
   localparam int FoldShiftA = 57;
   localparam int FoldShiftB = 62;
   localparam int FoldShiftC = 63;

   // 64x64 carry-less product, 128-bit result
   function automatic block_type clmul64(input half_type a, input half_type b);
      block_type p;
      p = '0;
      for (int i = 0; i < HalfWidth; i++) begin
         p = p ^ (({{HalfWidth{1'b0}}, a} << i) & {BlockWidth{b[i]}});
      end
      return p;
   endfunction

   function automatic half_type fold_up(input half_type v);
      return (v << FoldShiftA) ^ (v << FoldShiftB) ^ (v << FoldShiftC);
   endfunction

   function automatic half_type fold_down(input half_type v);
      return v ^ (v >> (HalfWidth - FoldShiftA)) ^ (v >> (HalfWidth - FoldShiftB))
             ^ (v >> (HalfWidth - FoldShiftC));
   endfunction

endpackage

[src/phash_gfmul.sv]
// gf(2^128) polyval multiply: carry-less 128x128 product with montgomery
// reduction by x^-128; depends on phash_pkg
`timescale 1ns / 1ps

module phash_gfmul (
   input  phash_pkg::block_type a,
   input  phash_pkg::block_type h,
   output phash_pkg::block_type r
);

   phash_pkg::block_type p0, p1, p2, p3;
   phash_pkg::half_type  z0, z1, z2, z3, w1, w2;

   always_comb begin
      p0 = phash_pkg::clmul64(a[63:0],   h[63:0]);
      p3 = phash_pkg::clmul64(a[127:64], h[127:64]);
      p1 = phash_pkg::clmul64(a[63:0],   h[127:64]);
      p2 = phash_pkg::clmul64(a[127:64], h[63:0]);

      z0 = p0[63:0];
      z1 = p0[127:64] ^ p1[63:0] ^ p2[63:0];
      z2 = p3[63:0] ^ p1[127:64] ^ p2[127:64];
      z3 = p3[127:64];

      // two folding rounds
      w1 = z1 ^ phash_pkg::fold_up(z0);
      w2 = z2 ^ phash_pkg::fold_down(z0);
      r  = {z3 ^ phash_pkg::fold_down(w1), w2 ^ phash_pkg::fold_up(w1)};
   end

endmodule

[src/polyval_hash_accumulator.sv]
// polyval hash accumulator top level: input register, accumulator update,
// tag output register and key registers; depends on phash_pkg, phash_gfmul
//
//   channel   direction   payload
//   req_*     in          tdata {block_hi, block_lo}, tuser first_block, tlast last_block
//   rsp_*     out         tdata {tag_hi, tag_lo}
//   csr_*     in          index 0 hash_key_lo, 1 hash_key_hi, wdata 64 bits
//
// one item per cycle unless a held tag stalls; a tag passes the input and tag registers
// the accumulator update is one gf(2^128) multiply from the input register
// reset clears the accumulator, key, and both valid flags
// a held tag stalls only an item with last_block behind it
`timescale 1ns / 1ps

module polyval_hash_accumulator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_lo, block_hi
   input  logic [0:0]   req_tuser,   // first_block
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // tag_lo, tag_hi
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   phash_pkg::block_type in_block_ff;
   logic                 in_first_ff;
   logic                 in_last_ff;
   phash_pkg::block_type acc_ff, acc_in;
   phash_pkg::half_type  key_lo_ff, key_hi_ff;
   logic                 out_valid_ff, out_valid_in;
   phash_pkg::block_type out_tag_ff;
   phash_pkg::block_type mul_a, mul_r;
   logic                 advance;
   logic                 req_take;

   assign advance    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign mul_a = (in_first_ff ? '0 : acc_ff) ^ in_block_ff;

   phash_gfmul u_gfmul (
      .a (mul_a),
      .h ({key_hi_ff, key_lo_ff}),
      .r (mul_r)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      acc_in       = advance ? mul_r : acc_ff;
      out_valid_in = (advance && in_last_ff) || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         key_lo_ff    <= '0;
         key_hi_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               phash_pkg::CsrHashKeyLo: key_lo_ff <= csr_wdata;
               phash_pkg::CsrHashKeyHi: key_hi_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_block_ff <= req_tdata;
         in_first_ff <= req_tuser[0];
         in_last_ff  <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_tag_ff <= mul_r;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_tag_ff;

endmodule

[src/phash_checker.sv]
// port-level checks for the polyval hash accumulator, bound to the top level
// depends on polyval_hash_accumulator port list only
`timescale 1ns / 1ps

module phash_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         csr_ready
);

   // a stalled tag holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("tag changed while stalled");

   // a new tag comes only from an accepted last item, through the input and tag registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("tag without a last item");

   // no tag right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("tag valid after reset");

   // key writes are never held off
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr port not ready");

endmodule

bind polyval_hash_accumulator phash_checker u_phash_checker (.*);

[dv/polyval_hash_accumulator_test.sv]
// self-checking bench for polyval_hash_accumulator: drives 128-bit blocks with
// first/last flags and key writes, predicts each tag in a scoreboard class
// depends on phash_pkg and the polyval_hash_accumulator rtl
`timescale 1ns / 1ps

module polyval_hash_accumulator_test;

   localparam int ClockHalf   = 6;
   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 4;
   localparam int IdlePercent = 22;
   localparam int HoldCycles  = 120;
   localparam int MaxReports  = 100;
   localparam int ProdWidth   = 2 * phash_pkg::BlockWidth;
   localparam phash_pkg::csr_idx_type CsrUnmapped = '1;
   // x^128 + x^127 + x^126 + x^121 + 1
   localparam logic [ProdWidth-1:0] ReductionPoly =
      ({{(ProdWidth-1){1'b0}}, 1'b1} << 128) | ({{(ProdWidth-1){1'b0}}, 1'b1} << 127) |
      ({{(ProdWidth-1){1'b0}}, 1'b1} << 126) | ({{(ProdWidth-1){1'b0}}, 1'b1} << 121) |
      {{(ProdWidth-1){1'b0}}, 1'b1};

   class polyval_scoreboard;
      phash_pkg::half_type  key_lo;
      phash_pkg::half_type  key_hi;
      phash_pkg::block_type acc;
      phash_pkg::block_type tags_due[$];
      int        mismatches;
      int        tags_seen;
      int        blocks_seen;
      int        messages;

      function new();
         key_lo = '0;
         key_hi = '0;
         acc = '0;
         mismatches = 0;
         tags_seen = 0;
         blocks_seen = 0;
         messages = 0;
      endfunction

      function void write_reg(phash_pkg::csr_idx_type idx, phash_pkg::half_type data);
         if (idx == phash_pkg::CsrHashKeyLo) key_lo = data;
         else if (idx == phash_pkg::CsrHashKeyHi) key_hi = data;
      endfunction

      // carry-less product, then bit-serial montgomery reduction by x^128
      function phash_pkg::block_type gf_mul(phash_pkg::block_type a,
                                            phash_pkg::block_type h);
         logic [ProdWidth-1:0] z;
         z = '0;
         for (int i = 0; i < phash_pkg::BlockWidth; i++) begin
            if (h[i]) z = z ^ ({{phash_pkg::BlockWidth{1'b0}}, a} << i);
         end
         for (int i = 0; i < phash_pkg::BlockWidth; i++) begin
            if (z[i]) z = z ^ (ReductionPoly << i);
         end
         return z[ProdWidth-1:phash_pkg::BlockWidth];
      endfunction

      function void absorb(phash_pkg::half_type lo, phash_pkg::half_type hi,
                           bit first, bit last);
         blocks_seen++;
         if (first) acc = '0;
         acc = gf_mul(acc ^ {hi, lo}, {key_hi, key_lo});
         if (last) begin
            tags_due.push_back(acc);
            messages++;
         end
      endfunction

      function int pending();
         return tags_due.size();
      endfunction

      task report(string what, phash_pkg::block_type got, phash_pkg::block_type want);
         if (mismatches < MaxReports)
            $display("mismatch %s: got %h want %h", what, got, want);
         mismatches++;
      endtask

      task check_tag(phash_pkg::block_type tag);
         phash_pkg::block_type want;
         tags_seen++;
         if (tags_due.size() == 0) begin
            report("unexpected tag", tag, '0);
            return;
         end
         want = tags_due.pop_front();
         if (tag[phash_pkg::HalfWidth-1:0] !== want[phash_pkg::HalfWidth-1:0])
            report("tag_lo",
                   phash_pkg::block_type'(tag[phash_pkg::HalfWidth-1:0]),
                   phash_pkg::block_type'(want[phash_pkg::HalfWidth-1:0]));
         if (tag[phash_pkg::BlockWidth-1:phash_pkg::HalfWidth] !==
             want[phash_pkg::BlockWidth-1:phash_pkg::HalfWidth])
            report("tag_hi",
                   phash_pkg::block_type'(tag[phash_pkg::BlockWidth-1:phash_pkg::HalfWidth]),
                   phash_pkg::block_type'(want[phash_pkg::BlockWidth-1:phash_pkg::HalfWidth]));
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // block_lo, block_hi
   logic [0:0]   req_tuser;   // first_block
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // tag_lo, tag_hi
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_index;
   logic [63:0]  csr_wdata;

   polyval_scoreboard sb;
   bit steady;
   bit hold_ask;
   int key_settings;
   int cycle_count = 0;

   polyval_hash_accumulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // tag receiver, with one long hold-off when asked
   initial begin
      int  hold_left;
      bit  hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask && !hold_used) begin
            hold_left = HoldCycles;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IdlePercent);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) sb.check_tag(rsp_tdata);
   end

   function automatic phash_pkg::half_type rand_half();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // called and returns at a falling edge
   task automatic send_block(phash_pkg::half_type lo, phash_pkg::half_type hi,
                             bit first, bit last);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < IdlePercent) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {hi, lo};
      req_tuser <= first;
      req_tlast <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.absorb(lo, hi, first, last);
      @(negedge clock);
   endtask

   // every tag out, then a drain wait for blocks that give no tag
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(phash_pkg::csr_idx_type idx, phash_pkg::half_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_key(phash_pkg::half_type lo, phash_pkg::half_type hi);
      write_reg(phash_pkg::CsrHashKeyLo, lo);
      write_reg(phash_pkg::CsrHashKeyHi, hi);
      key_settings++;
   endtask

   // well-formed messages of random length, with some stray flag combinations
   task automatic random_phase(int n_blocks);
      int sent;
      int len;
      sent = 0;
      while (sent < n_blocks) begin
         if ($urandom_range(9) == 0) begin
            send_block(rand_half(), rand_half(), $urandom_range(1), $urandom_range(1));
            sent++;
         end else begin
            len = hold_ask ? $urandom_range(1, 2) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               send_block(rand_half(), rand_half(), k == 0, k == len - 1);
            end
            sent += len;
         end
      end
      wait_idle();
   endtask

   initial begin
      sb = new();
      steady = 1'b0;
      hold_ask = 1'b0;
      key_settings = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // key still zero from reset
      send_block('1, '1, 1'b1, 1'b1);
      send_block(rand_half(), rand_half(), 1'b1, 1'b0);
      send_block(rand_half(), rand_half(), 1'b0, 1'b0);
      send_block(rand_half(), rand_half(), 1'b0, 1'b1);
      wait_idle();
      write_reg(CsrUnmapped, '1);
      set_key({$urandom, $urandom}, {$urandom, $urandom});

      // single-block messages at the data extremes
      send_block('0, '0, 1'b1, 1'b1);
      send_block('1, '1, 1'b1, 1'b1);
      send_block(64'd1, '0, 1'b1, 1'b1);
      send_block('0, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
      // message, then carry on from the tag without a restart
      send_block(rand_half(), rand_half(), 1'b1, 1'b0);
      send_block(rand_half(), rand_half(), 1'b0, 1'b0);
      send_block(rand_half(), rand_half(), 1'b0, 1'b1);
      send_block(rand_half(), rand_half(), 1'b0, 1'b0);
      send_block(rand_half(), rand_half(), 1'b0, 1'b1);
      // key change part way through a message
      send_block(rand_half(), rand_half(), 1'b1, 1'b0);
      wait_idle();
      write_reg(phash_pkg::CsrHashKeyHi, {$urandom, $urandom});
      key_settings++;
      send_block(rand_half(), rand_half(), 1'b0, 1'b1);
      // restart abandons an open message
      send_block(rand_half(), rand_half(), 1'b1, 1'b0);
      send_block(rand_half(), rand_half(), 1'b0, 1'b0);
      send_block(rand_half(), rand_half(), 1'b1, 1'b1);
      wait_idle();
      set_key('1, '1);
      send_block('1, '1, 1'b1, 1'b1);
      send_block(rand_half(), rand_half(), 1'b1, 1'b0);
      send_block(rand_half(), rand_half(), 1'b0, 1'b1);
      wait_idle();

      set_key(64'd1, '0);
      random_phase(125);
      set_key('0, 64'h8000_0000_0000_0000);
      hold_ask = 1'b1;
      random_phase(125);
      hold_ask = 1'b0;
      set_key({$urandom, $urandom}, {$urandom, $urandom});
      steady = 1'b1;
      random_phase(150);
      steady = 1'b0;
      write_reg(phash_pkg::csr_idx_type'($urandom_range(2**phash_pkg::CsrIdxWidth - 1,
                                                        phash_pkg::CsrHashKeyHi + 1)),
                {$urandom, $urandom});
      set_key('0, '0);
      random_phase(100);
      set_key({$urandom, $urandom}, {$urandom, $urandom});
      random_phase(125);
      set_key('1, {$urandom, $urandom});
      random_phase(125);
      wait_idle();

      $display("absorbed %0d blocks, closed %0d messages, compared %0d tags",
               sb.blocks_seen, sb.messages, sb.tags_seen);
      $display("keys set %0d times incl. zero, all-ones and single-bit keys",
               key_settings);
      $display("one long tag hold-off that filled the block");
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
